// ===== rtl/gripper_stall_detect_hold_core_assert.svh =====
// Assertion macros for the gripper stall detector. They sample on clk and are
// disabled while rst_n is low.
`ifndef GRIPPER_STALL_DETECT_HOLD_CORE_ASSERT_SVH
`define GRIPPER_STALL_DETECT_HOLD_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define GSDH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gripper stall detector: same-cycle check failed");

`define GSDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gripper stall detector: next-cycle check failed");

`else

`define GSDH_ASSERT_IMPLY(label, ante, cons)

`define GSDH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/gsdh_pkg.sv =====
package gsdh_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HOLD_BIAS     = 3'd0;
    localparam logic [2:0] CFG_STABLE_NEEDED = 3'd1;
    localparam logic [2:0] CFG_MIN_OFFSET    = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [2:0] CFG_SERVO_NUMBER  = 3'd4;

    // Input opcodes.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_HOLD    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [11:0] PULSE_MIN  = 12'd500;
    localparam logic [11:0] PULSE_MAX  = 12'd2500;
    localparam logic [8:0]  ANGLE_MAX  = 9'd270;
    localparam logic [9:0]  MOVE_TIME  = 10'd1000;
    localparam logic [9:0]  HOLD_TIME  = 10'd200;
    localparam logic [11:0] STILL_BAND = 12'd2;
    localparam logic [3:0]  COUNT_MAX  = 4'd15;
    localparam logic [13:0] TICKS_MAX  = 14'd16383;

    // angle * 200 / 27 is done as angle * (200 * ceil(2^21 / 27)) >> 21, which is
    // exact for every angle up to 270.
    localparam logic [23:0] ANGLE_SCALE = 24'd15534600;
    localparam int          ANGLE_SHIFT = 21;

    localparam logic [8:0] RESET_HOLD_BIAS     = 9'd20;
    localparam logic [3:0] RESET_STABLE_NEEDED = 4'd5;
    localparam logic [10:0] RESET_MIN_OFFSET   = 11'd20;
    localparam logic [13:0] RESET_TIMEOUT      = 14'd1600;

    typedef struct packed {
        logic [8:0]  hold_bias;
        logic [3:0]  stable_needed;
        logic [10:0] min_offset;
        logic [13:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [8:0]  target_angle;
        logic [11:0] position_reading;
        logic        read_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] command_pulse;
        logic [9:0]  move_time_ms;
        logic [11:0] stall_position;
    } result_t;

endpackage

// ===== rtl/gsdh_cfg.sv =====
module gsdh_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [13:0]         cfg_data,
    output gsdh_pkg::cfg_t      cfg
);

    logic [8:0]  hold_bias_reg;
    logic [3:0]  stable_needed_reg;
    logic [10:0] min_offset_reg;
    logic [13:0] timeout_ticks_reg;

    // The servo bus id is accepted but affects no result, so it is not stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_bias_reg     <= gsdh_pkg::RESET_HOLD_BIAS[8:0];
            stable_needed_reg <= gsdh_pkg::RESET_STABLE_NEEDED;
            min_offset_reg    <= gsdh_pkg::RESET_MIN_OFFSET;
            timeout_ticks_reg <= gsdh_pkg::RESET_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gsdh_pkg::CFG_HOLD_BIAS:     hold_bias_reg     <= cfg_data[8:0];
                gsdh_pkg::CFG_STABLE_NEEDED: stable_needed_reg <= cfg_data[3:0];
                gsdh_pkg::CFG_MIN_OFFSET:    min_offset_reg    <= cfg_data[10:0];
                gsdh_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                gsdh_pkg::CFG_SERVO_NUMBER:  ;
                default: ;
            endcase
        end
    end

    assign cfg.hold_bias     = hold_bias_reg;
    assign cfg.stable_needed = stable_needed_reg;
    assign cfg.min_offset    = min_offset_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

// ===== rtl/gsdh_step.sv =====
module gsdh_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  gsdh_pkg::item_t     item,
    input  gsdh_pkg::cfg_t      cfg,
    output logic                has_result,
    output gsdh_pkg::result_t   result,
    output logic                active
);

    logic        active_reg, active_next;
    logic [11:0] target_reg, target_next;
    logic [11:0] last_pos_reg, last_pos_next;
    logic        have_last_reg, have_last_next;
    logic [3:0]  count_reg, count_next;
    logic [13:0] elapsed_reg, elapsed_next;

    logic [8:0]  angle_sat;
    logic [31:0] angle_prod;
    logic [11:0] start_pulse;
    logic [13:0] ticks_inc;
    logic [11:0] pos;
    logic        pos_valid;
    logic [11:0] diff_last;
    logic [11:0] diff_target;
    logic        still;
    logic [3:0]  count_upd;
    logic        stalled;
    logic [12:0] hold_up;
    logic [12:0] hold_floor;
    logic [11:0] hold_pulse;

    assign angle_sat   = (item.target_angle > gsdh_pkg::ANGLE_MAX) ?
                         gsdh_pkg::ANGLE_MAX : item.target_angle;
    assign angle_prod  = 32'(angle_sat) * 32'(gsdh_pkg::ANGLE_SCALE);
    assign start_pulse = gsdh_pkg::PULSE_MIN +
                         {1'b0, angle_prod[gsdh_pkg::ANGLE_SHIFT +: 11]};

    assign ticks_inc = (elapsed_reg == gsdh_pkg::TICKS_MAX) ? elapsed_reg :
                       elapsed_reg + 14'd1;

    assign pos       = item.position_reading;
    assign pos_valid = item.read_ok && (pos >= gsdh_pkg::PULSE_MIN) &&
                       (pos <= gsdh_pkg::PULSE_MAX);

    assign diff_last   = (pos >= last_pos_reg) ? pos - last_pos_reg : last_pos_reg - pos;
    assign diff_target = (pos >= target_reg) ? pos - target_reg : target_reg - pos;

    assign still     = have_last_reg && (diff_last <= gsdh_pkg::STILL_BAND);
    assign count_upd = !still ? 4'd0 :
                       (count_reg == gsdh_pkg::COUNT_MAX) ? count_reg : count_reg + 4'd1;
    assign stalled   = (count_upd >= cfg.stable_needed) &&
                       (diff_target >= {1'b0, cfg.min_offset});

    // The hold pulse keeps pushing toward the target by the bias, clamped to the
    // legal pulse range.
    assign hold_up    = {1'b0, pos} + {4'b0, cfg.hold_bias};
    assign hold_floor = {1'b0, gsdh_pkg::PULSE_MIN} + {4'b0, cfg.hold_bias};

    always_comb
    begin
        if (target_reg < pos)
        begin
            if ({1'b0, pos} < hold_floor)
                hold_pulse = gsdh_pkg::PULSE_MIN;
            else
                hold_pulse = pos - {3'b0, cfg.hold_bias};
        end
        else
        begin
            if (hold_up > {1'b0, gsdh_pkg::PULSE_MAX})
                hold_pulse = gsdh_pkg::PULSE_MAX;
            else
                hold_pulse = hold_up[11:0];
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        target_next    = target_reg;
        last_pos_next  = last_pos_reg;
        have_last_next = have_last_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        has_result     = 1'b0;
        result         = '0;
        result.result_kind = gsdh_pkg::KIND_TIMEOUT;

        unique case (item.opcode)
            gsdh_pkg::OP_START:
            begin
                active_next          = 1'b1;
                target_next          = start_pulse;
                last_pos_next        = '0;
                have_last_next       = 1'b0;
                count_next           = '0;
                elapsed_next         = '0;
                has_result           = 1'b1;
                result.result_kind   = gsdh_pkg::KIND_MOVE;
                result.command_pulse = start_pulse;
                result.move_time_ms  = gsdh_pkg::MOVE_TIME;
            end
            gsdh_pkg::OP_SAMPLE:
            begin
                if (active_reg)
                begin
                    if (elapsed_reg >= cfg.timeout_ticks)
                    begin
                        active_next = 1'b0;
                        has_result  = 1'b1;
                    end
                    else if (pos_valid)
                    begin
                        count_next     = count_upd;
                        last_pos_next  = pos;
                        have_last_next = 1'b1;
                        if (stalled)
                        begin
                            active_next           = 1'b0;
                            has_result            = 1'b1;
                            result.result_kind    = gsdh_pkg::KIND_HOLD;
                            result.command_pulse  = hold_pulse;
                            result.move_time_ms   = gsdh_pkg::HOLD_TIME;
                            result.stall_position = pos;
                        end
                    end
                end
            end
            gsdh_pkg::OP_TICK:
            begin
                if (active_reg)
                begin
                    elapsed_next = ticks_inc;
                    if (ticks_inc >= cfg.timeout_ticks)
                    begin
                        active_next = 1'b0;
                        has_result  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            target_reg    <= '0;
            last_pos_reg  <= '0;
            have_last_reg <= 1'b0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            target_reg    <= target_next;
            last_pos_reg  <= last_pos_next;
            have_last_reg <= have_last_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    assign active = active_reg;

endmodule

// ===== rtl/gripper_stall_detect_hold_core.sv =====
// Gripper stall detector. Start, position sample and millisecond tick
// transactions enter through an input register, are evaluated against the
// attempt state combinationally, and any resulting move, hold or timeout
// command lands in an output register. One transaction is accepted every clock
// while the output side keeps up; a transaction's result is evaluated from the
// input register and captured in the output register, the input and output
// registers being the only two stages. A result held by a stalled output side
// stops the input register, and the input stalls for as long as the output
// does. Configuration writes are always accepted and should be issued only
// while no transaction is in flight.
`include "gripper_stall_detect_hold_core_assert.svh"

module gripper_stall_detect_hold_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [8:0]  target_angle,
    input  logic [11:0] position_reading,
    input  logic        read_ok,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [11:0] command_pulse,
    output logic [9:0]  move_time_ms,
    output logic [11:0] stall_position
);

    gsdh_pkg::cfg_t    cfg;
    gsdh_pkg::item_t   s1_item_reg;
    gsdh_pkg::result_t step_result;
    gsdh_pkg::result_t out_res_reg;
    logic              s1_valid_reg;
    logic              s1_fire;
    logic              step_has_result;
    logic              step_active;
    logic              out_valid_reg;

    assign cfg_ready = 1'b1;

    gsdh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The input stage moves on whenever the output register is empty or being
    // drained in this cycle.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.opcode           <= opcode;
            s1_item_reg.target_angle     <= target_angle;
            s1_item_reg.position_reading <= position_reading;
            s1_item_reg.read_ok          <= read_ok;
        end
    end

    gsdh_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_fire),
        .item       (s1_item_reg),
        .cfg        (cfg),
        .has_result (step_has_result),
        .result     (step_result),
        .active     (step_active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= step_has_result;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step_has_result)
            out_res_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_res_reg.result_kind;
    assign command_pulse  = out_res_reg.command_pulse;
    assign move_time_ms   = out_res_reg.move_time_ms;
    assign stall_position = out_res_reg.stall_position;

    `GSDH_ASSERT_IMPLY(a_cmd_pulse_range,
        out_valid && result_kind != gsdh_pkg::KIND_TIMEOUT,
        command_pulse >= gsdh_pkg::PULSE_MIN && command_pulse <= gsdh_pkg::PULSE_MAX)
    `GSDH_ASSERT_IMPLY(a_hold_fields,
        out_valid && result_kind == gsdh_pkg::KIND_HOLD,
        move_time_ms == gsdh_pkg::HOLD_TIME && stall_position >= gsdh_pkg::PULSE_MIN
        && stall_position <= gsdh_pkg::PULSE_MAX)
    `GSDH_ASSERT_NEXT(a_start_arms,
        s1_fire && s1_item_reg.opcode == gsdh_pkg::OP_START, step_active)
    `GSDH_ASSERT_NEXT(a_stage_holds,
        s1_valid_reg && !s1_fire, s1_valid_reg && $stable(s1_item_reg))

endmodule

// ===== dv/stall_hold_checker.sv =====
module stall_hold_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [8:0]  target_angle,
    input  logic [11:0] position_reading,
    input  logic        read_ok,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [11:0] command_pulse,
    input  logic [9:0]  move_time_ms,
    input  logic [11:0] stall_position,
    output int          fail_count,
    output int          pending
);
    import gsdh_pkg::*;

    // Register copies as the block should hold them.
    logic [8:0]  bias_reg    = 9'd20;
    logic [3:0]  need_reg    = 4'd5;
    logic [10:0] min_off_reg = 11'd20;
    logic [13:0] limit_reg   = 14'd1600;
    logic [7:0]  servo_reg   = 8'd2;

    // Attempt state.
    bit          gripping  = 1'b0;
    logic [11:0] aim_pulse = '0;
    logic [11:0] prev_pos  = '0;
    bit          seen_pos  = 1'b0;
    logic [3:0]  still_cnt = '0;
    logic [13:0] tick_cnt  = '0;

    result_t expected_cmds[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string msg);
        if (fail_count < 40)
            $display("stall_hold_checker @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Advances the attempt state by one transaction and returns 1 when it yields a command.
    function automatic bit grip_step(input item_t it, output result_t cmd);
        int angle;
        int step;
        int gap;
        int hold;
        cmd = '0;
        if (it.opcode == OP_START)
        begin
            angle = it.target_angle;
            if (angle > int'(ANGLE_MAX))
                angle = ANGLE_MAX;
            aim_pulse = 12'(int'(PULSE_MIN) + (angle * 200) / 27);
            gripping  = 1'b1;
            seen_pos  = 1'b0;
            prev_pos  = '0;
            still_cnt = '0;
            tick_cnt  = '0;
            cmd.result_kind   = KIND_MOVE;
            cmd.command_pulse = aim_pulse;
            cmd.move_time_ms  = MOVE_TIME;
            return 1'b1;
        end
        if (!gripping)
            return 1'b0;
        if (it.opcode == OP_TICK)
        begin
            if (tick_cnt != TICKS_MAX)
                tick_cnt++;
            if (tick_cnt >= limit_reg)
            begin
                gripping = 1'b0;
                cmd.result_kind = KIND_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end
        if (it.opcode != OP_SAMPLE)
            return 1'b0;
        // A sample that arrives past the deadline reports the timeout instead.
        if (tick_cnt >= limit_reg)
        begin
            gripping = 1'b0;
            cmd.result_kind = KIND_TIMEOUT;
            return 1'b1;
        end
        if (!it.read_ok || it.position_reading < PULSE_MIN || it.position_reading > PULSE_MAX)
            return 1'b0;

        step = int'(it.position_reading) - int'(prev_pos);
        gap  = int'(it.position_reading) - int'(aim_pulse);
        if (step < 0)
            step = -step;
        if (gap < 0)
            gap = -gap;
        if (seen_pos && step <= int'(STILL_BAND))
        begin
            if (still_cnt != COUNT_MAX)
                still_cnt++;
        end
        else
            still_cnt = '0;
        prev_pos = it.position_reading;
        seen_pos = 1'b1;

        if (still_cnt < need_reg || gap < int'(min_off_reg))
            return 1'b0;

        // Keep pushing past the stall point in the closing direction.
        if (aim_pulse < it.position_reading)
            hold = int'(it.position_reading) - int'(bias_reg);
        else
            hold = int'(it.position_reading) + int'(bias_reg);
        if (hold < int'(PULSE_MIN))
            hold = PULSE_MIN;
        if (hold > int'(PULSE_MAX))
            hold = PULSE_MAX;
        gripping = 1'b0;
        cmd.result_kind    = KIND_HOLD;
        cmd.command_pulse  = 12'(hold);
        cmd.move_time_ms   = HOLD_TIME;
        cmd.stall_position = it.position_reading;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   it;
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            bias_reg    = 9'd20;
            need_reg    = 4'd5;
            min_off_reg = 11'd20;
            limit_reg   = 14'd1600;
            servo_reg   = 8'd2;
            gripping    = 1'b0;
            aim_pulse   = '0;
            prev_pos    = '0;
            seen_pos    = 1'b0;
            still_cnt   = '0;
            tick_cnt    = '0;
            expected_cmds.delete();
            pending     = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.result_kind    = result_kind;
                got.command_pulse  = command_pulse;
                got.move_time_ms   = move_time_ms;
                got.stall_position = stall_position;
                if (expected_cmds.size() == 0)
                    report($sformatf("command kind %0d with nothing expected", result_kind));
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.result_kind !== want.result_kind)
                        report($sformatf("result_kind %0d, expected %0d",
                                         got.result_kind, want.result_kind));
                    if (got.command_pulse !== want.command_pulse)
                        report($sformatf("command_pulse %0d, expected %0d",
                                         got.command_pulse, want.command_pulse));
                    if (got.move_time_ms !== want.move_time_ms)
                        report($sformatf("move_time_ms %0d, expected %0d",
                                         got.move_time_ms, want.move_time_ms));
                    if (got.stall_position !== want.stall_position)
                        report($sformatf("stall_position %0d, expected %0d",
                                         got.stall_position, want.stall_position));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HOLD_BIAS:     bias_reg    = cfg_data[8:0];
                    CFG_STABLE_NEEDED: need_reg    = cfg_data[3:0];
                    CFG_MIN_OFFSET:    min_off_reg = cfg_data[10:0];
                    CFG_TIMEOUT_TICKS: limit_reg   = cfg_data[13:0];
                    CFG_SERVO_NUMBER:  servo_reg   = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                it.opcode           = opcode;
                it.target_angle     = target_angle;
                it.position_reading = position_reading;
                it.read_ok          = read_ok;
                if (grip_step(it, want))
                    expected_cmds.push_back(want);
            end

            pending = expected_cmds.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import gsdh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [13:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [8:0]  target_angle;
    logic [11:0] position_reading;
    logic        read_ok;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [11:0] command_pulse;
    logic [9:0]  move_time_ms;
    logic [11:0] stall_position;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int items_sent = 0;
    int stall_left = 0;
    int cycles = 0;

    gripper_stall_detect_hold_core dut (.*);

    stall_hold_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[gripper_stall_detect_hold_core] ERROR");
            $finish;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_item(input logic [1:0] op, input logic [8:0] ang,
                             input logic [11:0] pos, input logic ok);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid         = 1'b1;
        opcode           = op;
        target_angle     = ang;
        position_reading = pos;
        read_ok          = ok;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic start_grip(input logic [8:0] ang);
        send_item(OP_START, ang, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    endtask

    task automatic sample(input logic [11:0] pos, input logic ok);
        send_item(OP_SAMPLE, 9'($urandom_range(0, 511)), pos, ok);
    endtask

    task automatic tick();
        send_item(OP_TICK, 9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)));
    endtask

    // Occasionally slips a tick or a transaction the block should disregard.
    task automatic maybe_noise();
        case ($urandom_range(0, 11))
            0: tick();
            1: send_item(OP_SAMPLE, 9'($urandom_range(0, 511)),
                         12'($urandom_range(0, 4095)), 1'b0);
            2: send_item(OP_SAMPLE, 9'($urandom_range(0, 511)),
                         12'($urandom_range(0, 1) ? $urandom_range(0, 499)
                                                  : $urandom_range(2501, 4095)), 1'b1);
            3: send_item(OP_UNUSED, 9'($urandom_range(0, 511)),
                         12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
            default: ;
        endcase
    endtask

    // Lets every outstanding transaction drain out of the block.
    task automatic settle();
        in_valid = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input int bias, input int need, input int off, input int lim,
                             input int servo);
        settle();
        write_reg(CFG_HOLD_BIAS, 14'(bias));
        write_reg(CFG_STABLE_NEEDED, 14'(need));
        write_reg(CFG_MIN_OFFSET, 14'(off));
        write_reg(CFG_TIMEOUT_TICKS, 14'(lim));
        write_reg(CFG_SERVO_NUMBER, 14'(servo));
        // Writes to indexes past the last register must change nothing.
        write_reg(3'($urandom_range(5, 7)), 14'($urandom_range(0, 16383)));
        cfg_valid = 1'b0;
    endtask

    // One closing attempt: start, some travel, then a run of near-identical readings.
    task automatic close_jaw();
        int p;
        int n_move;
        int n_still;
        start_grip(9'(($urandom_range(0, 9) == 0) ? $urandom_range(271, 511)
                                                  : $urandom_range(0, 270)));
        p = $urandom_range(500, 2498);
        n_move = $urandom_range(0, 4);
        n_still = $urandom_range(0, 18);
        repeat (n_move)
        begin
            maybe_noise();
            sample(12'($urandom_range(500, 2500)), 1'b1);
        end
        repeat (n_still)
        begin
            maybe_noise();
            sample(12'(p + $urandom_range(0, 2)), 1'b1);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 70)) tick();
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        opcode           = OP_START;
        target_angle     = '0;
        position_reading = '0;
        read_ok          = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Transactions while idle are dropped.
        sample(12'd1000, 1'b1);
        tick();
        send_item(OP_UNUSED, 9'd511, 12'd4095, 1'b1);
        // Angle extremes, saturation above the top angle, and restarts.
        start_grip(9'd0);
        start_grip(9'd511);
        start_grip(9'd135);
        start_grip(9'd270);
        // Readings the attempt must ignore.
        sample(12'd1000, 1'b0);
        sample(12'd499, 1'b1);
        sample(12'd2501, 1'b1);
        sample(12'd4095, 1'b1);
        send_item(OP_UNUSED, 9'd0, 12'd1500, 1'b1);
        // Stall short of the target while closing upward.
        sample(12'd1000, 1'b1);
        sample(12'd1002, 1'b1);
        sample(12'd1001, 1'b1);
        sample(12'd1003, 1'b1);
        sample(12'd1003, 1'b1);
        sample(12'd1004, 1'b1);
        // Stall at the top of the range while closing downward.
        start_grip(9'd0);
        repeat (6) sample(12'd2500, 1'b1);

        phase = 0;
        while (items_sent < 500)
        begin
            case (phase)
                0: configure(500, 15, 2000, 9999, 255);
                1: configure(0, 0, 0, 0, 0);
                2: configure(500, 0, 0, 9999, $urandom_range(0, 255));
                default: configure($urandom_range(0, 500), $urandom_range(0, 15),
                                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2000)
                                                               : $urandom_range(0, 100),
                                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 9999)
                                                               : $urandom_range(0, 60),
                                   $urandom_range(0, 255));
            endcase
            repeat ($urandom_range(2, 5)) close_jaw();
            if (items_sent >= 420)
                calm = 1'b1;
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("[gripper_stall_detect_hold_core] OK");
        else
            $display("[gripper_stall_detect_hold_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gsdh_pkg.sv
rtl/gsdh_cfg.sv
rtl/gsdh_step.sv
rtl/gripper_stall_detect_hold_core.sv
dv/stall_hold_checker.sv
dv/testbench.sv
